### rtl/core/mas_pkg.sv
// Shared constants and types for the integer matrix engine.
`default_nettype none

package mas_pkg;

  localparam int DIM_MAX   = 16;
  localparam int NCELL     = (DIM_MAX < 16) ? DIM_MAX : 16;
  localparam int IDX_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int DATA_W    = 32;
  localparam int CAW       = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int AMEM_D    = NCELL * NCELL;
  localparam int AMEM_AW   = $clog2(AMEM_D);
  localparam int DRAIN_LEN = NCELL + 4;
  localparam int DRN_W     = $clog2(DRAIN_LEN + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 5;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;

  localparam logic [1:0] OP_WR_A = 2'd0;
  localparam logic [1:0] OP_WR_B = 2'd1;
  localparam logic [1:0] OP_REQ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd3;

  typedef struct packed {
    logic              vld;
    logic [CAW-1:0]    k;
    logic [DATA_W-1:0] a;
  } tok_t;

  typedef struct packed {
    logic              clr;
    logic              prod;
    logic              sub;
    logic [CAW-1:0]    row;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_row;
    logic [IDX_W-1:0]  wr_col;
    logic [DATA_W-1:0] wr_data;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/core/mas_cell.sv
// One column cell: holds a column of B and one result element, accumulated in product mode.
`default_nettype none

module mas_cell (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [mas_pkg::CAW-1:0]       col_id,
  input  wire  mas_pkg::ctl_t           ctl,
  input  wire  mas_pkg::tok_t           tok_in,
  output mas_pkg::tok_t                 tok_out,
  output logic [mas_pkg::DATA_W-1:0]    acc
);
  import mas_pkg::*;

  logic [DATA_W-1:0] bmem [NCELL];
  tok_t              tok_r;
  logic [DATA_W-1:0] b_q_r;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              take_r;
  logic              take_nxt;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] acc_nxt;
  logic [CAW-1:0]    rd_addr;
  logic [DATA_W-1:0] mul_lo;

  assign rd_addr = ctl.prod ? tok_in.k : ctl.row;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_col == IDX_W'(col_id))) begin
      bmem[ctl.wr_row[CAW-1:0]] <= ctl.wr_data;
    end
    if (tok_in.vld) begin
      b_q_r <= bmem[rd_addr];
    end
  end

  assign mul_lo = tok_r.a * b_q_r;

  always_comb begin
    take_nxt = tok_r.vld && (ctl.prod || (tok_r.k == col_id));
    if (ctl.prod) begin
      val_nxt = mul_lo;
    end else if (ctl.sub) begin
      val_nxt = tok_r.a - b_q_r;
    end else begin
      val_nxt = tok_r.a + b_q_r;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (take_r) begin
      acc_nxt = ctl.prod ? (acc_r + val_r) : val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      take_r    <= 1'b0;
    end else begin
      tok_r.vld <= tok_in.vld;
      take_r    <= take_nxt;
    end
    tok_r.k <= tok_in.k;
    tok_r.a <= tok_in.a;
    val_r   <= val_nxt;
    acc_r   <= acc_nxt;
  end

  assign tok_out = tok_r;
  assign acc     = acc_r;

endmodule

`default_nettype wire

### rtl/core/matrix_add_sub_multiply.sv
// Top level of the integer matrix engine: A store, request sequencer and cell chain.
`default_nettype none

// Matrix A lives in a 256-entry memory; matrix B is spread over a chain of 16
// column cells, each holding one column and one accumulator. Writes of A or B
// are accepted only while the sequencer is idle. A row request streams A
// elements of that row through the cell chain, one per cycle: inner_used
// elements for the product and cols_used for add and subtract. After the
// stream, the sequencer waits in its drain state for the token to pass all 16
// cells and their multiply and accumulate stages, then delivers cols_used
// results, one per cycle when out_ready is high. Requests for a row beyond
// rows_used are accepted and produce no results. Reading an element that was
// never written returns an undefined value.
module matrix_add_sub_multiply (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       in_op,
  input  wire  [mas_pkg::IDX_W-1:0]        in_row_index,
  input  wire  [mas_pkg::IDX_W-1:0]        in_col_index,
  input  wire  signed [mas_pkg::DATA_W-1:0] in_element,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [mas_pkg::IDX_W-1:0]        out_row,
  output logic [mas_pkg::IDX_W-1:0]        out_col,
  output logic signed [mas_pkg::DATA_W-1:0] out_value,
  output logic                             out_last,
  input  wire                              cfg_wr_en,
  input  wire  [mas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [mas_pkg::CFG_W-1:0]        cfg_wdata
);
  import mas_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FEED  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [SIZE_W-1:0]  LIM_S = SIZE_W'(NCELL);
  localparam logic [AMEM_AW-1:0] NC_A  = AMEM_AW'(NCELL);

  logic [1:0]        mode_r;
  logic [SIZE_W-1:0] rows_r;
  logic [SIZE_W-1:0] inner_r;
  logic [SIZE_W-1:0] cols_r;
  logic [SIZE_W-1:0] nr;
  logic [SIZE_W-1:0] nk;
  logic [SIZE_W-1:0] nc;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [SIZE_W-1:0] cnt_r;
  logic [SIZE_W-1:0] cnt_nxt;
  logic [SIZE_W-1:0] n_r;
  logic [SIZE_W-1:0] n_nxt;
  logic [SIZE_W-1:0] nc_r;
  logic [SIZE_W-1:0] nc_nxt;
  logic [DRN_W-1:0]  dcnt_r;
  logic [DRN_W-1:0]  dcnt_nxt;
  logic [IDX_W-1:0]  req_row_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;
  logic              out_load;

  logic [DATA_W-1:0] amem [AMEM_D];
  logic [DATA_W-1:0] a_q_r;
  logic              tok_vld_r;
  logic [CAW-1:0]    tok_k_r;

  logic              accept;
  logic              is_prod;
  logic              req_go;
  logic              in_range;
  logic              feed;
  logic [AMEM_AW-1:0] wr_addr;
  logic [AMEM_AW-1:0] rd_addr;

  ctl_t              ctl;
  tok_t              chain [NCELL+1];
  logic [DATA_W-1:0] acc_w [NCELL];

  assign nr = (rows_r  > LIM_S) ? LIM_S : rows_r;
  assign nk = (inner_r > LIM_S) ? LIM_S : inner_r;
  assign nc = (cols_r  > LIM_S) ? LIM_S : cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ADD;
      rows_r  <= SIZE_W'(1);
      inner_r <= SIZE_W'(1);
      cols_r  <= SIZE_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[1:0];
        CFG_ROWS:  rows_r  <= cfg_wdata;
        CFG_INNER: inner_r <= cfg_wdata;
        CFG_COLS:  cols_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign is_prod  = mode_r[1];
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign req_go   = accept && (in_op == OP_REQ) && (SIZE_W'(in_row_index) < nr) &&
                    (nc != '0);
  assign in_range = (SIZE_W'(in_row_index) < LIM_S) && (SIZE_W'(in_col_index) < LIM_S);
  assign feed     = (state_r == ST_FEED);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    nc_nxt        = nc_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (req_go) begin
          n_nxt    = is_prod ? nk : nc;
          nc_nxt   = nc;
          cnt_nxt  = '0;
          dcnt_nxt = '0;
          state_nxt = ((is_prod ? nk : nc) == '0) ? ST_DRAIN : ST_FEED;
        end
      end
      ST_FEED: begin
        cnt_nxt = cnt_r + SIZE_W'(1);
        if (cnt_r == n_r - SIZE_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        dcnt_nxt = dcnt_r + DRN_W'(1);
        if (dcnt_r == DRN_W'(DRAIN_LEN - 1)) begin
          state_nxt = ST_OUT;
          cnt_nxt   = '0;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r + SIZE_W'(1);
          if (cnt_r == nc_r - SIZE_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      nc_r        <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      tok_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      nc_r        <= nc_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      tok_vld_r   <= feed;
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      req_row_r <= in_row_index;
    end
    if (out_load) begin
      out_row_r   <= req_row_r;
      out_col_r   <= cnt_r[IDX_W-1:0];
      out_value_r <= acc_w[cnt_r[CAW-1:0]];
      out_last_r  <= (cnt_r == nc_r - SIZE_W'(1));
    end
  end

  assign wr_addr = AMEM_AW'(in_row_index) * NC_A + AMEM_AW'(in_col_index);
  assign rd_addr = AMEM_AW'(req_row_r) * NC_A + AMEM_AW'(cnt_r);

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_WR_A) && in_range) begin
      amem[wr_addr] <= in_element;
    end
    if (feed) begin
      a_q_r   <= amem[rd_addr];
      tok_k_r <= cnt_r[CAW-1:0];
    end
  end

  always_comb begin
    ctl.clr     = req_go;
    ctl.prod    = is_prod;
    ctl.sub     = (mode_r == MODE_SUB);
    ctl.row     = req_row_r[CAW-1:0];
    ctl.wr_en   = accept && (in_op == OP_WR_B) && in_range;
    ctl.wr_row  = in_row_index;
    ctl.wr_col  = in_col_index;
    ctl.wr_data = in_element;
  end

  assign chain[0].vld = tok_vld_r;
  assign chain[0].k   = tok_k_r;
  assign chain[0].a   = a_q_r;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    mas_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .col_id  (CAW'(j)),
      .ctl     (ctl),
      .tok_in  (chain[j]),
      .tok_out (chain[j+1]),
      .acc     (acc_w[j])
    );
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  a_tok_from_feed: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld_r |-> $past(state_r) == ST_FEED)
    else $error("token issued outside the feed phase");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result appeared outside the output phase");

  a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (cnt_r < nc_r))
    else $error("output column count ran past the row");

  a_feed_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FEED) |-> (cnt_r < n_r))
    else $error("feed count ran past the stream length");

endmodule

`default_nettype wire
